// File: rtl/pmenc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmenc_pkg
// Types and constants of the performance-state multiplier encoder: field
// widths, clamp limits, the divisor table and the divide-by-three reciprocal.
// ----------------------------------------------------------------------------
package pmenc_pkg;

  localparam int REG_W   = 64;
  localparam int MULT_W  = 13;
  localparam int VID_W   = 7;
  localparam int NUM_W   = 6;
  localparam int FID_W   = 5;
  localparam int DID_W   = 4;
  localparam int IN_W    = 88;
  localparam int OUT_W   = 88;

  localparam int NUM_DIVS   = 9;
  localparam int GROUP_SIZE = 3;
  localparam int NUM_GROUPS = 3;

  // multipliers in units of 1/96
  localparam logic [MULT_W-1:0] MULT_LO = 13'd96;
  localparam logic [MULT_W-1:0] MULT_HI = 13'd4512;

  // numerator range, frequency code is numerator minus NUM_LO
  localparam logic [NUM_W-1:0] NUM_LO = 6'd16;
  localparam logic [NUM_W-1:0] NUM_HI = 6'd47;

  // floor(x / 3) = (x * RECIP3) >> RECIP_SHIFT, exact for x < 8192
  localparam int              RECIP_W     = 12;
  localparam int              RECIP_SHIFT = 13;
  localparam int              PROD_W      = MULT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP3   = 12'd2731;

  // divisor step in units of 1/96 per numerator: 96 / divisor; codes 9..15 have none
  localparam logic [6:0] DIV_UNITS [16] = '{
    7'd96, 7'd64, 7'd48, 7'd32, 7'd24, 7'd16, 7'd12, 7'd8,
    7'd6,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
  };

  // step = (2^shift) or (3 * 2^shift)
  localparam logic [2:0] DIV_SHIFT [NUM_DIVS] = '{
    3'd5, 3'd6, 3'd4, 3'd5, 3'd3, 3'd4, 3'd2, 3'd3, 3'd1
  };
  localparam logic DIV_BY3 [NUM_DIVS] = '{
    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
  };

  localparam logic [DID_W-1:0] DID_COUNT = 4'd9;

endpackage
`default_nettype wire

// File: rtl/pstate_multiplier_encoder_top.sv
`default_nettype none
// Path: an accepted word passes stages 1 to 4 and the output register to out_tdata.
// Throughput: one word per cycle while out_tready is high; five register stages
// with a valid bit each, a stage advancing when empty or when the stage after it advances.
// Reset: rst_n (synchronous, active low) empties all stages; payload is not reset.
// ----------------------------------------------------------------------------
// pstate_multiplier_encoder_top
// Clamps the target multiplier, finds the best numerator/divisor pair over
// nine divisors and rewrites the performance-state register when needed.
// ----------------------------------------------------------------------------
module pstate_multiplier_encoder_top
  import pmenc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // old_register[63:0], target_multiplier[76:64], target_vid[83:77], zero pad
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // new_register[63:0], write_needed[64], new_fid[69:65], new_did[73:70],
  // old_multiplier[86:74], old_divisor_invalid[87]
  output logic [OUT_W-1:0]      out_tdata
);

  // stage enables
  logic out_en, s4_en, s3_en, s2_en, s1_en;

  // stage 1: captured word
  logic              s1_v_r;
  logic [REG_W-1:0]  s1_old_r;
  logic [MULT_W-1:0] s1_m_r;
  logic [VID_W-1:0]  s1_vid_r;

  // stage 2: numerator per divisor
  logic              s2_v_r;
  logic [REG_W-1:0]  s2_old_r;
  logic [VID_W-1:0]  s2_vid_r;
  logic [MULT_W-1:0] s2_omult_r, s2_omult_nxt;
  logic              s2_inv_r, s2_inv_nxt;
  logic [NUM_W-1:0]  s2_n_r   [NUM_DIVS];
  logic [NUM_W-1:0]  s2_n_nxt [NUM_DIVS];
  logic              s2_ok_r   [NUM_DIVS];
  logic              s2_ok_nxt [NUM_DIVS];

  // stage 3: quotient per divisor
  logic              s3_v_r;
  logic [REG_W-1:0]  s3_old_r;
  logic [VID_W-1:0]  s3_vid_r;
  logic [MULT_W-1:0] s3_omult_r;
  logic              s3_inv_r;
  logic [MULT_W-1:0] s3_q_r     [NUM_DIVS];
  logic [MULT_W-1:0] s3_q_nxt   [NUM_DIVS];
  logic [FID_W-1:0]  s3_fid_r   [NUM_DIVS];
  logic [FID_W-1:0]  s3_fid_nxt [NUM_DIVS];

  // stage 4: best of each group of three
  logic              s4_v_r;
  logic [REG_W-1:0]  s4_old_r;
  logic [VID_W-1:0]  s4_vid_r;
  logic [MULT_W-1:0] s4_omult_r;
  logic              s4_inv_r;
  logic [MULT_W-1:0] s4_q_r     [NUM_GROUPS];
  logic [MULT_W-1:0] s4_q_nxt   [NUM_GROUPS];
  logic [FID_W-1:0]  s4_fid_r   [NUM_GROUPS];
  logic [FID_W-1:0]  s4_fid_nxt [NUM_GROUPS];
  logic [DID_W-1:0]  s4_did_r   [NUM_GROUPS];
  logic [DID_W-1:0]  s4_did_nxt [NUM_GROUPS];

  // output register
  logic              out_v_r;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  assign out_en    = !out_v_r || out_tready;
  assign s4_en     = !s4_v_r || out_en;
  assign s3_en     = !s3_v_r || s4_en;
  assign s2_en     = !s2_v_r || s3_en;
  assign s1_en     = !s1_v_r || s2_en;
  assign in_tready = s1_en;

  // --------------------------------------------------------------------------
  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_tvalid;
    end
    if (s1_en && in_tvalid) begin
      s1_old_r <= in_tdata[REG_W-1:0];
      s1_m_r   <= in_tdata[REG_W +: MULT_W];
      s1_vid_r <= in_tdata[REG_W+MULT_W +: VID_W];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: clamp, then n = floor(m / step) per divisor
  logic [MULT_W-1:0] m_clamp;
  logic [DID_W-1:0]  old_did;
  logic [NUM_W-1:0]  old_num;

  assign m_clamp = (s1_m_r < MULT_LO) ? MULT_LO :
                   (s1_m_r > MULT_HI) ? MULT_HI : s1_m_r;

  for (genvar i = 0; i < NUM_DIVS; i++) begin : g_lane_div
    logic [MULT_W-1:0] sh;
    logic [PROD_W-1:0] prod;
    logic [MULT_W-1:0] n_raw;
    assign sh    = m_clamp >> DIV_SHIFT[i];
    assign prod  = {{RECIP_W{1'b0}}, sh} * {{MULT_W{1'b0}}, RECIP3};
    assign n_raw = DIV_BY3[i] ? {1'b0, prod[PROD_W-1:RECIP_SHIFT]} : sh;
    assign s2_ok_nxt[i] = (n_raw >= {{(MULT_W-NUM_W){1'b0}}, NUM_LO});
    assign s2_n_nxt[i]  = (n_raw > {{(MULT_W-NUM_W){1'b0}}, NUM_HI}) ? NUM_HI
                                                                    : n_raw[NUM_W-1:0];
  end

  // decode the old multiplier; unused divisor codes give a zero step
  assign old_did      = s1_old_r[DID_W-1:0];
  assign old_num      = {1'b0, s1_old_r[DID_W +: FID_W]} + NUM_LO;
  assign s2_inv_nxt   = (old_did >= DID_COUNT);
  assign s2_omult_nxt = {{(MULT_W-NUM_W){1'b0}}, old_num} *
                        {{(MULT_W-7){1'b0}}, DIV_UNITS[old_did]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_en && s1_v_r) begin
      s2_old_r   <= s1_old_r;
      s2_vid_r   <= s1_vid_r;
      s2_omult_r <= s2_omult_nxt;
      s2_inv_r   <= s2_inv_nxt;
      s2_n_r     <= s2_n_nxt;
      s2_ok_r    <= s2_ok_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: quotient q = n * step; zero marks a numerator below range
  for (genvar i = 0; i < NUM_DIVS; i++) begin : g_lane_quot
    logic [NUM_W-1:0] fid_w;
    assign s3_q_nxt[i] = s2_ok_r[i] ?
                         ({{(MULT_W-NUM_W){1'b0}}, s2_n_r[i]} *
                          {{(MULT_W-7){1'b0}}, DIV_UNITS[i]}) : '0;
    assign fid_w         = s2_n_r[i] - NUM_LO;
    assign s3_fid_nxt[i] = fid_w[FID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_en) begin
      s3_v_r <= s2_v_r;
    end
    if (s3_en && s2_v_r) begin
      s3_old_r   <= s2_old_r;
      s3_vid_r   <= s2_vid_r;
      s3_omult_r <= s2_omult_r;
      s3_inv_r   <= s2_inv_r;
      s3_q_r     <= s3_q_nxt;
      s3_fid_r   <= s3_fid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: best of each group; strictly greater replaces, so ties keep the earlier
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      s4_q_nxt[g]   = s3_q_r[g*GROUP_SIZE];
      s4_fid_nxt[g] = s3_fid_r[g*GROUP_SIZE];
      s4_did_nxt[g] = DID_W'(g*GROUP_SIZE);
      for (int k = 1; k < GROUP_SIZE; k++) begin
        if (s3_q_r[g*GROUP_SIZE+k] > s4_q_nxt[g]) begin
          s4_q_nxt[g]   = s3_q_r[g*GROUP_SIZE+k];
          s4_fid_nxt[g] = s3_fid_r[g*GROUP_SIZE+k];
          s4_did_nxt[g] = DID_W'(g*GROUP_SIZE+k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_en) begin
      s4_v_r <= s3_v_r;
    end
    if (s4_en && s3_v_r) begin
      s4_old_r   <= s3_old_r;
      s4_vid_r   <= s3_vid_r;
      s4_omult_r <= s3_omult_r;
      s4_inv_r   <= s3_inv_r;
      s4_q_r     <= s4_q_nxt;
      s4_fid_r   <= s4_fid_nxt;
      s4_did_r   <= s4_did_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output stage: final pick, compare against old codes, rewrite low 16 bits
  logic [MULT_W-1:0] best_q;
  logic [FID_W-1:0]  best_fid;
  logic [DID_W-1:0]  best_did;
  logic              wr;
  logic [REG_W-1:0]  new_reg;

  always_comb begin
    best_q   = s4_q_r[0];
    best_fid = s4_fid_r[0];
    best_did = s4_did_r[0];
    for (int g = 1; g < NUM_GROUPS; g++) begin
      if (s4_q_r[g] > best_q) begin
        best_q   = s4_q_r[g];
        best_fid = s4_fid_r[g];
        best_did = s4_did_r[g];
      end
    end
  end

  assign wr      = ({best_fid, best_did} != s4_old_r[FID_W+DID_W-1:0]);
  assign new_reg = wr ? {s4_old_r[REG_W-1:16], s4_vid_r, best_fid, best_did} : s4_old_r;
  assign out_data_nxt = {s4_inv_r, s4_omult_r, best_did, best_fid, wr, new_reg};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= s4_v_r;
    end
    if (out_en && s4_v_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions

  // the low nine bits of the result always carry the chosen codes
  a_codes_in_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:0] == {out_tdata[69:65], out_tdata[73:70]}))
    else $error("new register codes differ from new_fid/new_did");

  // an invalid old divisor can never match, so it forces a write
  a_inv_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[87]) |-> (out_tdata[64] && (out_tdata[86:74] == '0)))
    else $error("invalid old divisor without write or with nonzero multiplier");

  // chosen divisor index stays within the table
  a_did_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[73:70] < DID_COUNT))
    else $error("new_did out of range");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
